// ===== rtl/core/indexed_list_engine_macros.svh =====
// Assertion helpers for the list engine.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off while in reset.
`define ILE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("indexed_list_engine: same-cycle check failed");

// Next-cycle implication, held off while in reset.
`define ILE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("indexed_list_engine: next-cycle check failed");

`else

`define ILE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ILE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ilist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ilist_pkg;

    // Largest supported capacity and the count width that can hold it
    localparam int unsigned CAP_MAX             = 256;
    localparam int unsigned CNT_MAX_W           = $clog2(CAP_MAX + 1);
    localparam int unsigned DEFAULT_CAPACITY    = 16;
    localparam int unsigned DEFAULT_ENTRY_WIDTH = 32;

    // Fixed port field widths
    localparam int unsigned KIND_W   = 4;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned FILL_W   = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH        = 4'd0,
        KIND_POP         = 4'd1,
        KIND_INSERT      = 4'd2,
        KIND_REMOVE      = 4'd3,
        KIND_REMOVE_SWAP = 4'd4,
        KIND_GET         = 4'd5,
        KIND_FIRST       = 4'd6,
        KIND_LAST        = 4'd7,
        KIND_CLEAR       = 4'd8,
        KIND_RESIZE      = 4'd9
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What the cell row does with the current beat
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,    // load at pos, cells above pos up to used take left neighbour
        CELL_REMOVE,    // cells from pos up to used-2 take right neighbour
        CELL_SWAP,      // cell at pos takes the read bus (last entry)
        CELL_ZERO       // cells from used up to nlen-1 clear
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [CNT_MAX_W-1:0]   pos;
        logic [CNT_MAX_W-1:0]   used;
        logic [CNT_MAX_W-1:0]   nlen;
        logic                   rd_en;
        logic [CNT_MAX_W-1:0]   rd_idx;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/ilist_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ilist_cell import ilist_pkg::*; #(
    parameter int unsigned ENTRY_WIDTH = DEFAULT_ENTRY_WIDTH,
    parameter int unsigned INDEX       = 0
) (
    input  wire logic                   i_clk,
    input  wire t_cell_ctrl             i_ctrl,
    input  wire logic [ENTRY_WIDTH-1:0] i_load,
    input  wire logic [ENTRY_WIDTH-1:0] i_bus,
    input  wire logic [ENTRY_WIDTH-1:0] i_left,
    input  wire logic [ENTRY_WIDTH-1:0] i_right,
    output logic      [ENTRY_WIDTH-1:0] o_data,
    output logic      [ENTRY_WIDTH-1:0] o_tap
);

    logic [CNT_MAX_W-1:0]   w_idx;
    logic [CNT_MAX_W-1:0]   w_idx_nx;
    logic [CNT_MAX_W-1:0]   w_pos_nx;
    logic [ENTRY_WIDTH-1:0] r_data;
    logic [ENTRY_WIDTH-1:0] n_data;

    assign w_idx    = CNT_MAX_W'(INDEX);
    assign w_idx_nx = w_idx + 1'b1;
    assign w_pos_nx = i_ctrl.pos + 1'b1;

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (w_idx == i_ctrl.pos) begin
                    n_data = i_load;
                end else if (w_idx > i_ctrl.pos && w_idx <= i_ctrl.used) begin
                    n_data = i_left;
                end
            end
            CELL_REMOVE: begin
                if (w_idx >= i_ctrl.pos && w_idx_nx < i_ctrl.used) begin
                    n_data = i_right;
                end
            end
            CELL_SWAP: begin
                if (w_idx == i_ctrl.pos && w_pos_nx < i_ctrl.used) begin
                    n_data = i_bus;
                end
            end
            CELL_ZERO: begin
                if (w_idx >= i_ctrl.used && w_idx < i_ctrl.nlen) begin
                    n_data = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // contributes to the OR-combined read bus only when addressed
    assign o_tap  = (i_ctrl.rd_en && i_ctrl.rd_idx == w_idx) ? r_data : '0;

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
//  Channel   Direction  Handshake                  Payload
//  request   in         i_in_valid / o_in_stall    i_kind i_position i_value i_new_length
//  result    out        o_out_valid / i_out_stall  o_status o_read_value o_slot o_fill_level
//
//  One request per cycle while o_in_stall is low: every cell of the row updates on the
//  accepting edge, so an insert or remove shifts the whole list at once; the result is
//  registered in the output register, or in the skid register while that is stalled.
//  A skid register behind the output register lets one more beat in while a result is
//  stalled; o_in_stall rises only when that skid register is occupied.
//  Synchronous active-low reset clears the fill level and both result stages; the
//  entries are not cleared and hold whatever they last held.

module indexed_list_engine import ilist_pkg::*; #(
    parameter int unsigned CAPACITY    = DEFAULT_CAPACITY,
    parameter int unsigned ENTRY_WIDTH = DEFAULT_ENTRY_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic [VALUE_W-1:0]  i_value,
    input  wire logic [POS_W-1:0]    i_new_length,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [VALUE_W-1:0]  o_read_value,
    output logic      [SLOT_W-1:0]   o_slot,
    output logic      [FILL_W-1:0]   o_fill_level
);

`include "indexed_list_engine_macros.svh"

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_MAX_W-1:0] CAP_CNT = CNT_MAX_W'(CAPACITY);

    // ---------------------------------------------------------------- fill level
    logic [CNT_W-1:0]       r_used;
    logic [CNT_MAX_W-1:0]   w_used;
    logic                   w_accept;

    assign w_used   = CNT_MAX_W'(r_used);
    assign w_accept = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------- value width
    logic [ENTRY_WIDTH-1:0] w_val;
    logic [ENTRY_WIDTH-1:0] w_rv;
    logic [VALUE_W-1:0]     w_rv_out;

    generate
        if (ENTRY_WIDTH > VALUE_W) begin : g_wide
            assign w_val    = {{(ENTRY_WIDTH-VALUE_W){1'b0}}, i_value};
            assign w_rv_out = w_rv[VALUE_W-1:0];
        end else if (ENTRY_WIDTH == VALUE_W) begin : g_same
            assign w_val    = i_value;
            assign w_rv_out = w_rv;
        end else begin : g_narrow
            assign w_val    = i_value[ENTRY_WIDTH-1:0];
            assign w_rv_out = {{(VALUE_W-ENTRY_WIDTH){1'b0}}, w_rv};
        end
    endgenerate

    // ---------------------------------------------------------------- request decode
    logic [CNT_MAX_W-1:0]   w_pos;
    logic [CNT_MAX_W-1:0]   w_pos_nx;
    logic [CNT_MAX_W-1:0]   w_nlen;
    logic [CNT_MAX_W-1:0]   w_nused;
    logic [CNT_MAX_W-1:0]   w_slot;
    t_status                w_status;
    t_cell_ctrl             w_ctrl;
    logic [ENTRY_WIDTH-1:0] w_bus;

    assign w_pos    = CNT_MAX_W'(i_position);
    assign w_pos_nx = w_pos + 1'b1;
    assign w_nlen   = CNT_MAX_W'(i_new_length);

    always_comb begin
        w_status      = ST_OK;
        w_nused       = w_used;
        w_slot        = '0;
        w_rv          = '0;
        w_ctrl.op     = CELL_HOLD;
        w_ctrl.pos    = w_pos;
        w_ctrl.used   = w_used;
        w_ctrl.nlen   = w_nlen;
        w_ctrl.rd_en  = 1'b0;
        w_ctrl.rd_idx = '0;
        unique case (i_kind)
            KIND_PUSH: begin
                if (w_used == CAP_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    // append is an insert at the end
                    w_ctrl.op  = CELL_INSERT;
                    w_ctrl.pos = w_used;
                    w_nused    = w_used + 1'b1;
                    w_rv       = w_val;
                    w_slot     = w_used;
                end
            end
            KIND_POP: begin
                if (w_used == '0) begin
                    w_status = ST_RANGE;
                end else begin
                    w_nused = w_used - 1'b1;
                    w_slot  = w_used - 1'b1;
                end
            end
            KIND_INSERT: begin
                if (w_pos > w_used) begin
                    w_status = ST_RANGE;
                end else if (w_used == CAP_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.op = CELL_INSERT;
                    w_nused   = w_used + 1'b1;
                    w_rv      = w_val;
                    w_slot    = w_pos;
                end
            end
            KIND_REMOVE: begin
                if (w_pos >= w_used) begin
                    w_status = ST_RANGE;
                end else begin
                    // result is the entry that slides down into the hole
                    w_ctrl.op     = CELL_REMOVE;
                    w_ctrl.rd_en  = w_pos_nx < w_used;
                    w_ctrl.rd_idx = w_pos_nx;
                    w_nused       = w_used - 1'b1;
                    w_rv          = w_bus;
                    w_slot        = w_pos;
                end
            end
            KIND_REMOVE_SWAP: begin
                if (w_pos >= w_used) begin
                    w_status = ST_RANGE;
                end else begin
                    // the bus carries the last entry, both to the hole and to the result
                    w_ctrl.op     = CELL_SWAP;
                    w_ctrl.rd_en  = w_pos_nx < w_used;
                    w_ctrl.rd_idx = w_used - 1'b1;
                    w_nused       = w_used - 1'b1;
                    w_rv          = w_bus;
                    w_slot        = w_pos;
                end
            end
            KIND_GET: begin
                if (w_pos >= w_used) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.rd_en  = 1'b1;
                    w_ctrl.rd_idx = w_pos;
                    w_rv          = w_bus;
                    w_slot        = w_pos;
                end
            end
            KIND_FIRST: begin
                if (w_used == '0) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.rd_en = 1'b1;
                    w_rv         = w_bus;
                end
            end
            KIND_LAST: begin
                if (w_used == '0) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.rd_en  = 1'b1;
                    w_ctrl.rd_idx = w_used - 1'b1;
                    w_rv          = w_bus;
                    w_slot        = w_used - 1'b1;
                end
            end
            KIND_CLEAR: begin
                w_nused = '0;
            end
            KIND_RESIZE: begin
                if (w_nlen > CAP_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    // grown entries come up zeroed
                    w_ctrl.op = CELL_ZERO;
                    w_nused   = w_nlen;
                end
            end
            default: begin
                // unused kind codes: no-op with ok status
            end
        endcase
        if (!w_accept) begin
            w_ctrl.op = CELL_HOLD;
        end
    end

    // ---------------------------------------------------------------- cell row
    logic [ENTRY_WIDTH-1:0] w_cell_data [CAPACITY];
    logic [ENTRY_WIDTH-1:0] w_cell_tap  [CAPACITY];

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ENTRY_WIDTH-1:0] w_left;
            logic [ENTRY_WIDTH-1:0] w_right;

            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cell_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell_data[g+1];
            end

            ilist_cell #(
                .ENTRY_WIDTH (ENTRY_WIDTH),
                .INDEX       (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_load  (w_val),
                .i_bus   (w_bus),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_cell_data[g]),
                .o_tap   (w_cell_tap[g])
            );
        end
    endgenerate

    // read bus: at most one cell drives a non-zero tap
    always_comb begin
        w_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_bus = w_bus | w_cell_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (w_accept) begin
            r_used <= w_nused[CNT_W-1:0];
        end
    end

    // ---------------------------------------------------------------- result stage + skid
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VALUE_W-1:0]  r_out_rv;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [FILL_W-1:0]   r_out_fill;
    logic                r_skid_valid;
    logic [STATUS_W-1:0] r_skid_status;
    logic [VALUE_W-1:0]  r_skid_rv;
    logic [SLOT_W-1:0]   r_skid_slot;
    logic [FILL_W-1:0]   r_skid_fill;
    logic                w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_status <= r_skid_status;
                r_out_rv     <= r_skid_rv;
                r_out_slot   <= r_skid_slot;
                r_out_fill   <= r_skid_fill;
            end else if (w_accept) begin
                r_out_status <= w_status;
                r_out_rv     <= w_rv_out;
                r_out_slot   <= w_slot[SLOT_W-1:0];
                r_out_fill   <= w_nused[FILL_W-1:0];
            end
        end else if (w_accept) begin
            r_skid_status <= w_status;
            r_skid_rv     <= w_rv_out;
            r_skid_slot   <= w_slot[SLOT_W-1:0];
            r_skid_fill   <= w_nused[FILL_W-1:0];
        end
    end

    assign o_in_stall   = r_skid_valid;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_rv;
    assign o_slot       = r_out_slot;
    assign o_fill_level = r_out_fill;

    // ---------------------------------------------------------------- checks
    `ILE_ASSERT_IMP(a_used_in_range, i_clk, i_rst_n, 1'b1, w_used <= CAP_CNT)
    `ILE_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ILE_ASSERT_NEXT(a_error_keeps_level, i_clk, i_rst_n, w_accept && w_status != ST_OK, $stable(r_used))
    `ILE_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_accept && i_kind == KIND_PUSH && w_status == ST_OK, r_used == $past(r_used) + 1'b1)

endmodule

`default_nettype wire

// ===== sim/tb_indexed_list_engine.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the list engine.
// A short scripted opening walks the empty, full and boundary cases; a long random
// run then swings the fill level up and down between empty and full. Every accepted
// request goes through a local model of the list, and each result beat is compared
// field by field with the oldest expectation in the queue.
module tb_indexed_list_engine import ilist_pkg::*; ();

    localparam int unsigned CAPACITY       = 16;
    localparam int unsigned ENTRY_WIDTH    = 32;
    localparam int unsigned RANDOM_BEATS   = 1024;
    localparam int unsigned WATCHDOG_LIMIT = 1000;   // cycles with no beat on either side
    localparam int unsigned DRAIN_CYCLES   = 10;

    // Kinds with no operation behind them: the engine must answer ok and touch nothing
    localparam logic [KIND_W-1:0] KIND_RESERVED_FIRST = 4'd10;
    localparam logic [KIND_W-1:0] KIND_RESERVED_LAST  = 4'd15;

    localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

    // Scripted rows either carry their answer or defer to the model
    localparam bit TYPED = 1'b1;
    localparam bit MODEL = 1'b0;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   new_length;
    } t_list_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_value;
        logic [SLOT_W-1:0]   slot;
        logic [FILL_W-1:0]   fill_level;
    } t_list_reply;

    typedef struct packed {
        t_list_request req;
        bit            typed;
        t_list_reply   reply;
    } t_script_row;

    localparam int unsigned SCRIPT_ROWS = 26;

    // Opening script, starting from the empty list after reset
    localparam t_script_row OPENING_SCRIPT [SCRIPT_ROWS] = '{
        // empty list: every read or removal is out of range
        '{'{KIND_POP,         5'd0,  32'h0,        5'd0}, TYPED, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        '{'{KIND_FIRST,       5'd0,  32'h0,        5'd0}, TYPED, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        '{'{KIND_LAST,        5'd0,  32'h0,        5'd0}, TYPED, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        '{'{KIND_GET,         5'd0,  32'h0,        5'd0}, TYPED, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        '{'{KIND_REMOVE,      5'd0,  32'h0,        5'd0}, TYPED, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        '{'{KIND_REMOVE_SWAP, 5'd0,  32'h0,        5'd0}, TYPED, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        // insert one past the end
        '{'{KIND_INSERT,      5'd1,  32'hDEADBEEF, 5'd0}, TYPED, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        // resize beyond capacity reports full
        '{'{KIND_RESIZE,      5'd0,  32'h0,        5'd31}, TYPED, '{ST_FULL, 32'h0, 4'd0, 5'd0}},
        '{'{KIND_RESERVED_LAST, 5'd31, ALL_ONES,   5'd31}, TYPED, '{ST_OK, 32'h0, 4'd0, 5'd0}},
        '{'{KIND_PUSH,        5'd0,  ALL_ONES,     5'd0}, TYPED, '{ST_OK, ALL_ONES, 4'd0, 5'd1}},
        // insert at the head, then append by insert at the end, then in the middle
        '{'{KIND_INSERT,      5'd0,  32'h0,        5'd0}, MODEL, '0},
        '{'{KIND_INSERT,      5'd2,  32'hA5A5A5A5, 5'd0}, MODEL, '0},
        '{'{KIND_INSERT,      5'd1,  32'h12345678, 5'd0}, MODEL, '0},
        '{'{KIND_GET,         5'd31, 32'h0,        5'd0}, TYPED, '{ST_RANGE, 32'h0, 4'd0, 5'd4}},
        '{'{KIND_GET,         5'd4,  32'h0,        5'd0}, TYPED, '{ST_RANGE, 32'h0, 4'd0, 5'd4}},
        '{'{KIND_FIRST,       5'd0,  32'h0,        5'd0}, MODEL, '0},
        '{'{KIND_LAST,        5'd0,  32'h0,        5'd0}, MODEL, '0},
        '{'{KIND_REMOVE,      5'd1,  32'h0,        5'd0}, MODEL, '0},
        '{'{KIND_REMOVE_SWAP, 5'd0,  32'h0,        5'd0}, MODEL, '0},
        // grow to capacity; the new entries are zeroed
        '{'{KIND_RESIZE,      5'd0,  32'h0,        5'd16}, TYPED, '{ST_OK, 32'h0, 4'd0, 5'd16}},
        '{'{KIND_PUSH,        5'd0,  32'h1,        5'd0}, TYPED, '{ST_FULL, 32'h0, 4'd0, 5'd16}},
        // position check passes at the end, then the full check trips
        '{'{KIND_INSERT,      5'd16, 32'h1,        5'd0}, TYPED, '{ST_FULL, 32'h0, 4'd0, 5'd16}},
        '{'{KIND_INSERT,      5'd17, 32'h1,        5'd0}, TYPED, '{ST_RANGE, 32'h0, 4'd0, 5'd16}},
        // swap-remove of the last entry leaves nothing at the position
        '{'{KIND_REMOVE_SWAP, 5'd15, 32'h0,        5'd0}, MODEL, '0},
        '{'{KIND_RESERVED_FIRST, 5'd3, 32'h5A5A5A5A, 5'd7}, MODEL, '0},
        '{'{KIND_CLEAR,       5'd0,  32'h0,        5'd0}, TYPED, '{ST_OK, 32'h0, 4'd0, 5'd0}}
    };

    logic                i_clk;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic [KIND_W-1:0]   i_kind       = '0;
    logic [POS_W-1:0]    i_position   = '0;
    logic [VALUE_W-1:0]  i_value      = '0;
    logic [POS_W-1:0]    i_new_length = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [VALUE_W-1:0]  o_read_value;
    logic [SLOT_W-1:0]   o_slot;
    logic [FILL_W-1:0]   o_fill_level;

    // Model of the list contents and fill level
    logic [ENTRY_WIDTH-1:0] list_mem [CAPACITY] = '{default: '0};
    int unsigned            list_len = 0;

    t_list_reply replies_due [$];
    int unsigned fault_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned calm_beats   = 0;
    bit          filling      = 1'b1;

    indexed_list_engine #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_new_length (i_new_length),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_slot       (o_slot),
        .o_fill_level (o_fill_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one request to the list model and returns the result it should give.
    // Any error leaves the list untouched with zero read value and slot.
    function automatic t_list_reply apply_list_request(t_list_request req);
        t_list_reply            r;
        int unsigned            pos;
        int unsigned            nlen;
        int unsigned            i;
        int unsigned            slot_idx;
        logic [ENTRY_WIDTH-1:0] data;
        logic [ENTRY_WIDTH-1:0] seen;
        pos      = 32'(req.position);
        nlen     = 32'(req.new_length);
        data     = req.value[ENTRY_WIDTH-1:0];
        seen     = '0;
        slot_idx = 0;
        r.status = ST_OK;
        case (req.kind)
            KIND_PUSH: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = data;
                    seen     = data;
                    slot_idx = list_len;
                    list_len++;
                end
            end
            KIND_POP: begin
                if (list_len == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    list_len--;
                    slot_idx = list_len;
                end
            end
            KIND_INSERT: begin
                // range is checked ahead of capacity
                if (pos > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = data;
                    seen     = data;
                    slot_idx = pos;
                    list_len++;
                end
            end
            KIND_REMOVE, KIND_REMOVE_SWAP: begin
                if (pos >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    if (req.kind == KIND_REMOVE) begin
                        for (i = pos; i + 1 < list_len; i++)
                            list_mem[i] = list_mem[i+1];
                    end else if (pos + 1 < list_len) begin
                        list_mem[pos] = list_mem[list_len-1];
                    end
                    list_len--;
                    seen     = (pos < list_len) ? list_mem[pos] : '0;
                    slot_idx = pos;
                end
            end
            KIND_GET: begin
                if (pos >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    seen     = list_mem[pos];
                    slot_idx = pos;
                end
            end
            KIND_FIRST, KIND_LAST: begin
                if (list_len == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    slot_idx = (req.kind == KIND_FIRST) ? 0 : list_len - 1;
                    seen     = list_mem[slot_idx];
                end
            end
            KIND_CLEAR: begin
                list_len = 0;
            end
            KIND_RESIZE: begin
                if (nlen > CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i < nlen; i++)
                        list_mem[i] = '0;
                    list_len = nlen;
                end
            end
            default: ;
        endcase
        r.read_value = VALUE_W'(seen);
        r.slot       = slot_idx[SLOT_W-1:0];
        r.fill_level = list_len[FILL_W-1:0];
        return r;
    endfunction

    // Mostly short idles, now and then a long one
    function automatic int unsigned idle_cycles();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Gap ahead of the next request beat; calm stretches send back to back
    function automatic int unsigned request_gap();
        if (calm_beats != 0) begin
            calm_beats--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_beats = $urandom_range(20, 60);
            return 0;
        end
        if ($urandom_range(0, 99) < 55)
            return 0;
        return idle_cycles();
    endfunction

    // Random request biased by a fill direction, so the list keeps travelling
    // between empty and full and the shifts run over every length.
    function automatic t_list_request random_request();
        t_list_request req;
        int unsigned   roll;
        if (list_len == 0)
            filling = 1'b1;
        else if (list_len == CAPACITY && $urandom_range(0, 3) == 0)
            filling = 1'b0;
        roll           = $urandom_range(0, 99);
        req.value      = ($urandom_range(0, 9) != 0) ? VALUE_W'($urandom()) :
                         ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
        req.new_length = POS_W'($urandom_range(0, 31));
        // mostly in range, with one past the end as a natural boundary
        if ($urandom_range(0, 9) == 0)
            req.position = POS_W'($urandom_range(0, 31));
        else
            req.position = POS_W'($urandom_range(0, list_len));
        if (roll < 40) begin
            if (filling)
                req.kind = (roll < 25) ? KIND_PUSH : KIND_INSERT;
            else
                req.kind = (roll < 15) ? KIND_POP : (roll < 28) ? KIND_REMOVE : KIND_REMOVE_SWAP;
        end else if (roll < 50) begin
            if (filling)
                req.kind = (roll < 45) ? KIND_POP : KIND_REMOVE;
            else
                req.kind = (roll < 45) ? KIND_PUSH : KIND_INSERT;
        end else if (roll < 54) begin
            req.kind = KIND_REMOVE_SWAP;
        end else if (roll < 70) begin
            req.kind = KIND_GET;
        end else if (roll < 76) begin
            req.kind = KIND_FIRST;
        end else if (roll < 82) begin
            req.kind = KIND_LAST;
        end else if (roll < 83) begin
            req.kind = KIND_CLEAR;
        end else if (roll < 93) begin
            req.kind = KIND_RESIZE;
            if ($urandom_range(0, 6) != 0)
                req.new_length = POS_W'($urandom_range(0, CAPACITY));
        end else begin
            req.kind = KIND_W'($urandom_range(KIND_RESERVED_FIRST, KIND_RESERVED_LAST));
        end
        return req;
    endfunction

    // Drives one request beat and holds it until accepted, then records the
    // expected result: typed in for scripted rows that carry one, else modelled.
    task automatic issue_request(t_list_request req, bit typed, t_list_reply typed_reply);
        int unsigned gap;
        t_list_reply modelled;
        gap = request_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= req.kind;
        i_position   <= req.position;
        i_value      <= req.value;
        i_new_length <= req.new_length;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        modelled = apply_list_request(req);
        replies_due.push_back(typed ? typed_reply : modelled);
    endtask

    function automatic void check_field(string field, logic [VALUE_W-1:0] want,
                                        logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fault_count++;
        end
    endfunction

    // Request side: reset, opening script, random run, drain, verdict
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int unsigned row = 0; row < SCRIPT_ROWS; row++)
            issue_request(OPENING_SCRIPT[row].req, OPENING_SCRIPT[row].typed,
                          OPENING_SCRIPT[row].reply);
        for (int unsigned n = 0; n < RANDOM_BEATS; n++)
            issue_request(random_request(), MODEL, '0);
        i_in_valid <= 1'b0;
        // the watchdog bounds this wait
        while (replies_due.size() != 0)
            @(posedge i_clk);
        // a drain wait to catch any stray result beat
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && replies_due.size() == 0) begin
            $display("tb_indexed_list_engine: PASS");
        end else begin
            $display("tb_indexed_list_engine: FAIL");
        end
        $finish;
    end

    // Result side back-pressure: stall bursts between runs of ready cycles
    initial begin
        int unsigned hold;
        int unsigned run;
        @(posedge i_clk);
        forever begin
            hold = ($urandom_range(0, 1) == 0) ? 0 : idle_cycles();
            run  = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 6);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
        end
    end

    // Result checker: every accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        t_list_reply want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (replies_due.size() == 0) begin
                $error("result beat with no request outstanding");
                fault_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("status", VALUE_W'(want.status), VALUE_W'(o_status));
                check_field("read_value", want.read_value, o_read_value);
                check_field("slot", VALUE_W'(want.slot), VALUE_W'(o_slot));
                check_field("fill_level", VALUE_W'(want.fill_level), VALUE_W'(o_fill_level));
            end
        end
    end

    // Watchdog: too long with no beat accepted on either channel ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_indexed_list_engine: FAIL");
            $finish;
        end
    end

endmodule
